// ===== hdl/ddo_pkg.sv =====
package ddo_pkg;

  // one sample beat
  typedef struct packed {
    logic               func;
    logic [31:0]        time_us;
    logic signed [15:0] rpm_right;
    logic signed [15:0] rpm_left;
  } sample_t;

  // one pose beat
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;
  } pose_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING  = 3'd6;

  localparam logic [15:0] RST_WHEEL_RADIUS   = 16'd5472;
  localparam logic [17:0] RST_WHEEL_BASE     = 18'd46531;
  localparam logic [15:0] RST_GEAR_RATIO     = 16'd1920;
  localparam logic [15:0] RST_TURN_THRESHOLD = 16'd66;

  // pi/30 in Q32, 2^80/(2*pi*1e6), CORDIC gain compensation in Q2.30
  localparam logic [63:0] KR_Q32   = 64'd449767923;
  localparam logic [63:0] W_Q64    = 64'd192406520023215637;
  localparam logic [63:0] US_PER_S = 64'd1000000;
  localparam logic [63:0] US_HALF  = 64'd500000;
  // 2^74/1e6 rounded up: floor(n/1e6) is the product >> 74 for n below 2^56
  localparam logic [63:0] US_RECIP_Q74 = 64'd18889465931478581;

  localparam int CXY_W = 34;
  localparam logic signed [CXY_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  localparam int MD_BITS = 64;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic        start;
    md_op_t      op;
    logic [63:0] a;
    logic [63:0] b;
  } md_cmd_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } md_rsp_t;

endpackage

// ===== hdl/ddo_muldiv.sv =====
// bit-serial multiply (shift-add, stops when multiplier runs out)
// and restoring divide, 64 quotient bits; quotient in res[63:0]
module ddo_muldiv import ddo_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_cmd_t cmd,
  output md_rsp_t rsp
);

  localparam int CNT_W = $clog2(MD_BITS) + 1;

  logic               busy;
  logic               done;
  md_op_t             op;
  logic [127:0]       acc;
  logic [127:0]       ash;
  logic [63:0]        bsh;
  logic [CNT_W-1:0]   cnt;
  logic [64:0]        rs;
  logic [65:0]        diff;
  logic               ge;

  // acc holds {remainder, dividend/quotient} while dividing
  assign rs   = {acc[127:64], acc[63]};
  assign diff = {1'b0, rs} - {2'b00, bsh};
  assign ge   = ~diff[65];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (cmd.start) begin
          busy <= 1'b1;
          op   <= cmd.op;
          bsh  <= cmd.b;
          cnt  <= '0;
          ash  <= {64'd0, cmd.a};
          acc  <= (cmd.op == MD_DIV) ? {64'd0, cmd.a} : 128'd0;
        end
      end else begin
        unique case (op)
          MD_MUL: begin
            if (bsh == 64'd0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (bsh[0]) acc <= acc + ash;
              ash <= {ash[126:0], 1'b0};
              bsh <= {1'b0, bsh[63:1]};
            end
          end
          MD_DIV: begin
            if (cnt == CNT_W'(MD_BITS)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              acc <= {(ge ? diff[63:0] : rs[63:0]), acc[62:0], ge};
              cnt <= cnt + 1'b1;
            end
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = acc;

endmodule

// ===== hdl/ddo_cordic.sv =====
// rotation-mode CORDIC, one micro-rotation per cycle
module ddo_cordic import ddo_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [31:0]             ang,
  output logic                    done,
  output logic signed [CXY_W-1:0] cos_q,
  output logic signed [CXY_W-1:0] sin_q
);

  localparam int CW = $clog2(STEPS + 1);

  logic                    busy;
  logic                    flip;
  logic [CW-1:0]           cnt;
  logic signed [CXY_W-1:0] x, y, z;
  logic signed [CXY_W-1:0] dx, dy, at;
  logic [31:0]             ang_q, ang_r;
  logic [4:0]              idx;

  assign ang_q = ang + 32'h4000_0000;
  assign ang_r = ang_q[31] ? (ang - 32'h8000_0000) : ang;
  assign idx   = 5'(cnt);
  assign dx    = y >>> cnt;
  assign dy    = x >>> cnt;
  assign at    = {2'b00, ATAN_TAB[idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          cnt  <= '0;
          flip <= ang_q[31];
          x    <= GAIN_Q30;
          y    <= '0;
          z    <= {{2{ang_r[31]}}, ang_r};
        end
      end else if (cnt == CW'(STEPS)) begin
        busy  <= 1'b0;
        done  <= 1'b1;
        cos_q <= flip ? -x : x;
        sin_q <= flip ? -y : y;
      end else begin
        cnt <= cnt + 1'b1;
        if (!z[CXY_W-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
      end
    end
  end

endmodule

// ===== hdl/differential_drive_odometry.sv =====
// Each sample runs on the shared bit-serial multiply/divide unit (one bit per cycle;
//   two divides on the slow-turn midpoint path, four on the arc path) and on the
//   CORDIC for each sine and cosine pair.
// Throughput: one sample at a time; reset-pose, first and rejected samples give
//   no beat. A finished pose waits in the output register.
// Reset (rst, synchronous): registers to defaults, pose zero, not started.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 24,
  parameter int MAX_DT_US    = 1000000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sample_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pose_t                out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int DT_W = $clog2(MAX_DT_US + 1);

  // sequencer: every step but idle/finish runs the shared unit or the CORDIC
  typedef enum logic [20:0] {
    ST_IDLE   = 21'b1,
    ST_M_RK   = 21'b1 << 1,   // radius * KR
    ST_M_NV   = 21'b1 << 2,   // |sum| * above
    ST_M_NW   = 21'b1 << 3,   // |dif| * above
    ST_M_GB   = 21'b1 << 4,   // gear * base
    ST_D_V    = 21'b1 << 5,   // linear speed
    ST_D_W    = 21'b1 << 6,   // turn rate
    ST_M_WDT  = 21'b1 << 7,   // |w| * dt
    ST_M_HEAD = 21'b1 << 8,   // heading step
    ST_C_0    = 21'b1 << 9,   // arc: sin/cos at start
    ST_C_1    = 21'b1 << 10,  // arc: sin/cos at end
    ST_M_AX   = 21'b1 << 11,
    ST_D_AX   = 21'b1 << 12,
    ST_M_AY   = 21'b1 << 13,
    ST_D_AY   = 21'b1 << 14,
    ST_M_DST  = 21'b1 << 15,  // midpoint: distance
    ST_D_DST  = 21'b1 << 16,  // over 1e6 by reciprocal multiply
    ST_C_M    = 21'b1 << 17,  // midpoint: sin/cos
    ST_M_RX   = 21'b1 << 18,
    ST_M_RY   = 21'b1 << 19,
    ST_FIN    = 21'b1 << 20
  } state_t;

  state_t state;
  logic   launched;

  // configuration
  logic [15:0]        wheel_radius;
  logic [17:0]        wheel_base;
  logic [15:0]        gear_ratio;
  logic [15:0]        turn_threshold;
  logic [31:0]        start_x, start_y, start_heading;

  // pose and timing state
  logic               started;
  logic [31:0]        prev_time;
  logic [31:0]        pose_x, pose_y, pose_heading;

  // per-sample work registers
  logic [DT_W-1:0]    dt;
  logic               sneg, dneg;
  logic [16:0]        smag, dmagr;
  logic [63:0]        t0, t1, t2;
  logic [31:0]        vmag, wmag;
  logic               vneg, wneg;
  logic [31:0]        dth, dhalf;
  logic signed [CXY_W-1:0] ca, sa;
  logic signed [CXY_W:0]   ds_r, dc_r;

  logic               in_acc, cfg_acc;
  logic [31:0]        dt_full;
  logic signed [16:0] rsum, rdif;
  logic [15:0]        g_eff;
  logic [17:0]        b_eff;

  md_cmd_t            md_cmd;
  md_rsp_t            md_rsp;
  logic               md_state, cord_state, step_done;
  logic               cord_start, cord_done;
  logic [31:0]        cord_ang;
  logic signed [CXY_W-1:0] cord_cos, cord_sin;

  logic [31:0]        sat_v;
  logic [63:0]        hi_p1, rk_sum;
  logic [CXY_W:0]     ds_mag, dc_mag;
  logic [CXY_W-1:0]   ca_mag, sa_mag;
  logic [31:0]        vel_s, ang_s;

  function automatic logic [31:0] sat_mag(input logic [63:0] q, input logic neg);
    if (neg) return (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] wrap32(input logic [31:0] m, input logic neg);
    return neg ? (32'd0 - m) : m;
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign dt_full = in_data.time_us - prev_time;
  assign rsum    = 17'(in_data.rpm_right) + 17'(in_data.rpm_left);
  assign rdif    = 17'(in_data.rpm_right) - 17'(in_data.rpm_left);
  assign g_eff   = (gear_ratio == 16'd0) ? 16'd1 : gear_ratio;
  assign b_eff   = (wheel_base == 18'd0) ? 18'd1 : wheel_base;

  // result helpers
  assign sat_v  = sat_mag(md_rsp.res[63:0], (state == ST_D_V) ? sneg : dneg);
  assign hi_p1  = md_rsp.res[127:64] + 64'd1;
  assign rk_sum = md_rsp.res[63:0] + 64'd536870912;
  assign ds_mag = ds_r[CXY_W] ? 35'(-ds_r) : 35'(ds_r);
  assign dc_mag = dc_r[CXY_W] ? 35'(-dc_r) : 35'(dc_r);
  assign ca_mag = ca[CXY_W-1] ? 34'(-ca) : 34'(ca);
  assign sa_mag = sa[CXY_W-1] ? 34'(-sa) : 34'(sa);
  assign vel_s  = wrap32(vmag, vneg);
  assign ang_s  = wrap32(wmag, wneg);

  // operand select for the shared unit and the CORDIC
  always_comb begin
    md_state   = 1'b1;
    cord_state = 1'b0;
    md_cmd.op  = MD_MUL;
    md_cmd.a   = 64'd0;
    md_cmd.b   = 64'd0;
    cord_ang   = pose_heading;
    unique case (state)
      ST_M_RK:   begin md_cmd.a = KR_Q32;          md_cmd.b = 64'(wheel_radius); end
      ST_M_NV:   begin md_cmd.a = t0;              md_cmd.b = 64'(smag);         end
      ST_M_NW:   begin md_cmd.a = t0;              md_cmd.b = 64'(dmagr);        end
      ST_M_GB:   begin md_cmd.a = 64'(b_eff);      md_cmd.b = 64'(g_eff);        end
      ST_D_V: begin
        md_cmd.op = MD_DIV;
        md_cmd.a  = t1 + (64'(g_eff) << 24);
        md_cmd.b  = 64'(g_eff) << 25;
      end
      ST_D_W: begin
        md_cmd.op = MD_DIV;
        md_cmd.a  = t0 + {1'b0, t2[63:1]};
        md_cmd.b  = t2;
      end
      ST_M_WDT:  begin md_cmd.a = 64'(wmag);       md_cmd.b = 64'(dt);           end
      ST_M_HEAD: begin md_cmd.a = t0;              md_cmd.b = W_Q64;             end
      ST_M_AX:   begin md_cmd.a = 64'(vmag);       md_cmd.b = 64'(ds_mag);       end
      ST_M_AY:   begin md_cmd.a = 64'(vmag);       md_cmd.b = 64'(dc_mag);       end
      ST_D_AX, ST_D_AY: begin
        md_cmd.op = MD_DIV;
        md_cmd.a  = t1 + (64'(wmag) << 13);
        md_cmd.b  = 64'(wmag) << 14;
      end
      ST_M_DST:  begin md_cmd.a = 64'(vmag);       md_cmd.b = 64'(dt);           end
      ST_D_DST:  begin md_cmd.a = t1 + US_HALF;    md_cmd.b = US_RECIP_Q74;      end
      ST_M_RX:   begin md_cmd.a = t0;              md_cmd.b = 64'(ca_mag);       end
      ST_M_RY:   begin md_cmd.a = t0;              md_cmd.b = 64'(sa_mag);       end
      ST_C_0: begin
        md_state   = 1'b0;
        cord_state = 1'b1;
      end
      ST_C_1: begin
        md_state   = 1'b0;
        cord_state = 1'b1;
        cord_ang   = pose_heading + dth;
      end
      ST_C_M: begin
        md_state   = 1'b0;
        cord_state = 1'b1;
        cord_ang   = pose_heading + dhalf;
      end
      default: md_state = 1'b0;
    endcase
  end

  assign md_cmd.start = md_state && !launched;
  assign cord_start   = cord_state && !launched;
  assign step_done    = md_state ? md_rsp.done : cord_done;

  ddo_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .cmd (md_cmd),
    .rsp (md_rsp)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .ang   (cord_ang),
    .done  (cord_done),
    .cos_q (cord_cos),
    .sin_q (cord_sin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      launched       <= 1'b0;
      started        <= 1'b0;
      prev_time      <= '0;
      pose_x         <= '0;
      pose_y         <= '0;
      pose_heading   <= '0;
      out_valid      <= 1'b0;
      wheel_radius   <= RST_WHEEL_RADIUS;
      wheel_base     <= RST_WHEEL_BASE;
      gear_ratio     <= RST_GEAR_RATIO;
      turn_threshold <= RST_TURN_THRESHOLD;
      start_x        <= '0;
      start_y        <= '0;
      start_heading  <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_WHEEL_RADIUS:   wheel_radius   <= cfg_data[15:0];
          REG_WHEEL_BASE:     wheel_base     <= cfg_data[17:0];
          REG_GEAR_RATIO:     gear_ratio     <= cfg_data[15:0];
          REG_TURN_THRESHOLD: turn_threshold <= cfg_data[15:0];
          REG_START_X:        start_x        <= cfg_data;
          REG_START_Y:        start_y        <= cfg_data;
          REG_START_HEADING:  start_heading  <= cfg_data;
          default: ;
        endcase
      end

      // the finish step reloads the output register itself
      if (out_valid && !out_stall && state != ST_FIN) out_valid <= 1'b0;

      if (state == ST_IDLE) begin
        if (in_acc) begin
          priority if (in_data.func) begin
            pose_x       <= '0;
            pose_y       <= '0;
            pose_heading <= '0;
          end else if (!started) begin
            pose_x       <= start_x;
            pose_y       <= start_y;
            pose_heading <= start_heading;
            prev_time    <= in_data.time_us;
            started      <= 1'b1;
          end else begin
            prev_time <= in_data.time_us;
            // zero or too-long interval: drop the sample
            if (dt_full != 32'd0 && dt_full <= 32'(MAX_DT_US)) begin
              dt    <= DT_W'(dt_full);
              sneg  <= rsum[16];
              dneg  <= rdif[16];
              smag  <= rsum[16] ? 17'(-rsum) : 17'(rsum);
              dmagr <= rdif[16] ? 17'(-rdif) : 17'(rdif);
              state <= ST_M_RK;
            end
          end
        end
      end else if (state == ST_FIN) begin
        if (!out_valid || !out_stall) begin
          out_valid        <= 1'b1;
          out_data.pos_x   <= pose_x;
          out_data.pos_y   <= pose_y;
          out_data.heading <= pose_heading;
          out_data.lin_vel <= vel_s;
          out_data.ang_vel <= ang_s;
          state            <= ST_IDLE;
        end
      end else if (!launched) begin
        launched <= 1'b1;
      end else if (step_done) begin
        launched <= 1'b0;
        unique case (state)
          ST_M_RK: begin t0 <= md_rsp.res[63:0]; state <= ST_M_NV; end
          ST_M_NV: begin t1 <= md_rsp.res[63:0]; state <= ST_M_NW; end
          ST_M_NW: begin t0 <= md_rsp.res[63:0]; state <= ST_M_GB; end
          ST_M_GB: begin t2 <= md_rsp.res[63:0] << 8; state <= ST_D_V; end
          ST_D_V: begin
            vmag  <= sat_v;
            vneg  <= sneg && (sat_v != 32'd0);
            state <= ST_D_W;
          end
          ST_D_W: begin
            wmag  <= sat_v;
            wneg  <= dneg && (sat_v != 32'd0);
            state <= ST_M_WDT;
          end
          ST_M_WDT: begin t0 <= md_rsp.res[63:0]; state <= ST_M_HEAD; end
          ST_M_HEAD: begin
            // full step rounds on bit 63; half step is (hi + 1) / 2
            dth   <= wrap32(md_rsp.res[95:64] + 32'(md_rsp.res[63]), wneg);
            dhalf <= wrap32(hi_p1[32:1], wneg);
            state <= (wmag > 32'(turn_threshold)) ? ST_C_0 : ST_M_DST;
          end
          ST_C_0: begin
            ca    <= cord_cos;
            sa    <= cord_sin;
            state <= ST_C_1;
          end
          ST_C_1: begin
            ds_r  <= {cord_sin[CXY_W-1], cord_sin} - {sa[CXY_W-1], sa};
            dc_r  <= {cord_cos[CXY_W-1], cord_cos} - {ca[CXY_W-1], ca};
            state <= ST_M_AX;
          end
          ST_M_AX: begin t1 <= md_rsp.res[63:0]; state <= ST_D_AX; end
          ST_D_AX: begin
            pose_x <= pose_x + wrap32(md_rsp.res[31:0], vneg ^ ds_r[CXY_W] ^ wneg);
            state  <= ST_M_AY;
          end
          ST_M_AY: begin t1 <= md_rsp.res[63:0]; state <= ST_D_AY; end
          ST_D_AY: begin
            pose_y       <= pose_y - wrap32(md_rsp.res[31:0], vneg ^ dc_r[CXY_W] ^ wneg);
            pose_heading <= pose_heading + dth;
            state        <= ST_FIN;
          end
          ST_M_DST: begin t1 <= md_rsp.res[63:0]; state <= ST_D_DST; end
          ST_D_DST: begin t0 <= 64'(md_rsp.res[127:74]); state <= ST_C_M; end
          ST_C_M: begin
            ca    <= cord_cos;
            sa    <= cord_sin;
            state <= ST_M_RX;
          end
          ST_M_RX: begin
            pose_x <= pose_x + wrap32(rk_sum[61:30], vneg ^ ca[CXY_W-1]);
            state  <= ST_M_RY;
          end
          ST_M_RY: begin
            pose_y       <= pose_y + wrap32(rk_sum[61:30], vneg ^ sa[CXY_W-1]);
            pose_heading <= pose_heading + dth;
            state        <= ST_FIN;
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  // a reset-pose beat clears the pose on the next edge
  a_reset_item: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.func) |=> (pose_x == 32'd0 && pose_y == 32'd0 &&
                                  pose_heading == 32'd0))
    else $error("reset-pose beat did not clear the pose");

  // the shared unit only finishes an operation the sequencer launched
  a_md_done: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> (launched && md_state))
    else $error("multiply/divide done without a launched step");

  a_cord_done: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> (launched && cord_state))
    else $error("CORDIC done without a launched step");

  // once initialized the block stays initialized until reset
  a_started: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(started))
    else $error("started flag dropped");

  // a finished pose leaves the sequencer with a beat on the output
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && (!out_valid || !out_stall)) |=> (out_valid && state == ST_IDLE))
    else $error("finished pose not presented");
`endif

endmodule
